// ===== hdl/assert_macros.svh =====
// shared assertion macros for the scanner checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SBPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sbps assertion failed");

// antecedent in one cycle implies consequent in the next
`define SBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbps assertion failed");

`endif

// ===== hdl/sbps_pkg.sv =====
package sbps_pkg;

  // field widths
  localparam int PIN_W  = 6;
  localparam int WORD_W = 12;
  localparam int KIND_W = 2;
  localparam int PHASE_W = 3;

  // stream widths, data widths padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 4;

  // pin and word masks
  localparam logic [PIN_W-1:0]  LOW_PINS  = 6'h3F;
  localparam logic [PIN_W-1:0]  SA_PINS   = 6'h30;
  localparam logic [3:0]        DIR_PINS  = 4'hF;
  localparam logic [WORD_W-1:0] WORD_MASK = 12'hFFF;

  // scan phases
  localparam logic [PHASE_W-1:0] PHASE_DIR    = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_SA     = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_DETECT = 3'd5;
  localparam logic [PHASE_W-1:0] PHASE_LAST   = 3'd6;

  // pad kinds
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_THREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SIX     = 2'd2;

  // control from the top level into one pad lane
  typedef struct packed {
    logic               step;
    logic [PHASE_W-1:0] phase;
  } lane_ctrl_t;

  // post-update status of one pad lane
  typedef struct packed {
    logic [WORD_W-1:0] now;
    logic [WORD_W-1:0] prev;
    logic [KIND_W-1:0] kind;
  } lane_stat_t;

endpackage

// ===== hdl/sbps_pad_lane.sv =====
module sbps_pad_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbps_pkg::lane_ctrl_t          ctrl,
  input  logic [sbps_pkg::PIN_W-1:0]    pins,
  output sbps_pkg::lane_stat_t          stat
);
  import sbps_pkg::*;

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] now_r, now_nxt;
  logic [WORD_W-1:0] before_r, before_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [3:0]        extra;
  logic [WORD_W-1:0] word_full;

  // per-phase sample handling
  always_comb begin
    word_nxt   = word_r;
    now_nxt    = now_r;
    before_nxt = before_r;
    kind_nxt   = kind_r;
    extra      = (kind_r == KIND_SIX) ? pins[3:0] : DIR_PINS;
    word_full  = word_r | {extra, 8'b0};
    if (ctrl.step) begin
      case (ctrl.phase)
        PHASE_DIR: begin
          word_nxt = {6'b0, pins & LOW_PINS};
        end
        PHASE_SA: begin
          word_nxt = word_r | {4'b0, pins & SA_PINS, 2'b0};
        end
        PHASE_DETECT: begin
          kind_nxt = (pins[3:0] == 4'b0) ? KIND_SIX : KIND_THREE;
        end
        PHASE_LAST: begin
          word_nxt   = word_full;
          before_nxt = now_r;
          now_nxt    = word_full ^ WORD_MASK;
        end
        default: begin
        end
      endcase
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r   <= '0;
      now_r    <= '0;
      before_r <= '0;
      kind_r   <= KIND_UNKNOWN;
    end else begin
      word_r   <= word_nxt;
      now_r    <= now_nxt;
      before_r <= before_nxt;
      kind_r   <= kind_nxt;
    end
  end

  // status as seen after this sample
  assign stat.now  = now_nxt;
  assign stat.prev = before_nxt;
  assign stat.kind = kind_nxt;

endmodule

// ===== hdl/six_button_pad_scanner.sv =====
// channel | dir | tdata (low bit up)                               | tuser
// in      | in  | pad_a_pins[5:0] pad_b_pins[11:6] query_mask[23:12]| query_pad[0]
// out     | out | th_level[0] scan_done[1] pad_a_buttons[13:2]       | pad_a_kind[1:0]
//         |     | pad_b_buttons[25:14] query_held[26]               | pad_b_kind[3:2]
//         |     | query_pressed[27] query_released[28]              |
//
// one beat per cycle sustained while out_tready is high; each beat passes
// through the input register and then the result register.
// the input register doubles as a skid stage: a beat is taken while a
// result waits, and in_tready drops only when both stages are full.
// rst_n is synchronous active low; it clears the scan phase, pad words,
// pad kinds and both valid flags.
module six_button_pad_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pad_a_pins[5:0], pad_b_pins[11:6], query_mask[23:12]
  input  logic [sbps_pkg::IN_DATA_W-1:0]     in_tdata,
  // query_pad[0]
  input  logic [sbps_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // th_level[0], scan_done[1], pad_a_buttons[13:2], pad_b_buttons[25:14],
  // query_held[26], query_pressed[27], query_released[28], zeros above
  output logic [sbps_pkg::OUT_DATA_W-1:0]    out_tdata,
  // pad_a_kind[1:0], pad_b_kind[3:2]
  output logic [sbps_pkg::OUT_USER_W-1:0]    out_tuser
);
  import sbps_pkg::*;

  logic                   s1_valid_r;
  logic [IN_DATA_W-1:0]   s1_data_r;
  logic [IN_USER_W-1:0]   s1_user_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0]  out_user_r, out_user_nxt;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic                   s1_adv;
  logic                   step;
  lane_ctrl_t             ctrl;
  lane_stat_t             stat_a, stat_b, stat_q;
  logic [WORD_W-1:0]      mask;
  logic                   now_any, before_any;
  logic                   th_level, scan_done;

  // handshake
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign step      = s1_valid_r && s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  // scan phase counter
  assign phase_nxt = (phase_r >= PHASE_LAST) ? PHASE_DIR : phase_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_DIR;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  assign ctrl.step  = step;
  assign ctrl.phase = phase_r;

  // pad lanes
  sbps_pad_lane u_lane_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .pins  (s1_data_r[5:0]),
    .stat  (stat_a)
  );

  sbps_pad_lane u_lane_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .pins  (s1_data_r[11:6]),
    .stat  (stat_b)
  );

  // query on the post-update words
  assign stat_q     = s1_user_r[0] ? stat_b : stat_a;
  assign mask       = s1_data_r[23:12];
  assign now_any    = |(stat_q.now & mask);
  assign before_any = |(stat_q.prev & mask);
  assign th_level   = !phase_nxt[0];
  assign scan_done  = (phase_r == PHASE_LAST);

  assign out_data_nxt = {3'b0, !now_any && before_any, now_any && !before_any, now_any,
                         stat_b.now, stat_a.now, scan_done, th_level};
  assign out_user_nxt = {stat_b.kind, stat_a.kind};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hdl/sbps_checker.sv =====
`include "assert_macros.svh"

module sbps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sbps_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sbps_pkg::*;

  // a stalled result beat keeps its payload
  `SBPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a committing beat always hands back TH high for the next scan
  `SBPS_ASSERT(a_done_th, !(out_tvalid && out_tdata[1]) || out_tdata[0])

  // newly pressed implies held
  `SBPS_ASSERT(a_pressed_held, !(out_tvalid && out_tdata[27]) || out_tdata[26])

  // newly released implies not held
  `SBPS_ASSERT(a_released_free, !(out_tvalid && out_tdata[28]) || !out_tdata[26])

endmodule

bind six_button_pad_scanner sbps_checker u_sbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
